/* hdl/mprw_pkg.sv */
package mprw_pkg;

  localparam int CHANNELS     = 4;
  localparam int WINDOW_SLOTS = 6;
  localparam int RATE_DIVISOR = 3;
  localparam int COUNT_WIDTH  = 16;

  localparam int PERIOD_W   = 16;
  localparam int ACT_W      = 3;
  localparam int RATE_W     = 17;
  localparam int CH_W       = 2;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam int CNT_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W      = $clog2(WINDOW_SLOTS);
  localparam int RING_DEPTH = CHANNELS * WINDOW_SLOTS;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int SUM_W      = COUNT_WIDTH + $clog2(WINDOW_SLOTS);

  // floor(x / RATE_DIVISOR) as (x * DIV_MULT) >> DIV_SHIFT, exact for x below 2**SUM_W
  localparam int DIV_SHIFT  = SUM_W + $clog2(RATE_DIVISOR);
  localparam longint DIV_MULT = ((longint'(1) << DIV_SHIFT) + RATE_DIVISOR - 1) / RATE_DIVISOR;
  localparam int MULT_W     = DIV_SHIFT + 1;
  localparam int PROD_W     = SUM_W + MULT_W;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = '1;
  localparam logic [PERIOD_W-1:0]    PERIOD_RESET = PERIOD_W'(500);
  localparam logic [ACT_W-1:0]       ACTIVE_RESET = ACT_W'(4);

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic {
    REG_PERIOD = 1'b0,
    REG_ACTIVE = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_UPD,
    ST_ADV,
    ST_MUL,
    ST_STR,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic take_in;
    logic cnt_clr;
    logic cnt_inc;
    logic rd;
    logic upd;
    logic adv;
    logic mul;
    logic str;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic tick_sample;
    logic cnt_last;
    logic wrapped;
    logic out_free;
  } sts_t;

endpackage

/* hdl/mprw_in_if.sv */
interface mprw_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [1:0] channel;

  modport source (output valid, output op, output channel, input ready);
  modport sink   (input valid, input op, input channel, output ready);
endinterface

/* hdl/mprw_out_if.sv */
interface mprw_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] rate_ch0;
  logic [16:0] rate_ch1;
  logic [16:0] rate_ch2;
  logic [16:0] rate_ch3;
  logic        window_full;

  modport source (output valid, output rate_ch0, output rate_ch1, output rate_ch2,
                  output rate_ch3, output window_full, input ready);
  modport sink   (input valid, input rate_ch0, input rate_ch1, input rate_ch2,
                  input rate_ch3, input window_full, output ready);
endinterface

/* hdl/mprw_ram.sv */
module mprw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/mprw_ctrl.sv */
module mprw_ctrl import mprw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.tick_sample) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD:   state_nxt = ST_UPD;
      ST_UPD:  state_nxt = sts.cnt_last ? ST_ADV : ST_RD;
      ST_ADV:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = sts.wrapped ? ST_STR : ST_IDLE;
      ST_STR:  state_nxt = sts.cnt_last ? ST_EMIT : ST_MUL;
      ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.take_in = in_valid;
        cmd.cnt_clr = 1'b1;
      end
      ST_RD:   cmd.rd = 1'b1;
      ST_UPD: begin
        cmd.upd     = 1'b1;
        cmd.cnt_inc = !sts.cnt_last;
      end
      ST_ADV: begin
        cmd.adv     = 1'b1;
        cmd.cnt_clr = 1'b1;
      end
      ST_MUL:  cmd.mul = 1'b1;
      ST_STR: begin
        cmd.str     = 1'b1;
        cmd.cnt_inc = !sts.cnt_last;
      end
      ST_EMIT: cmd.emit = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* hdl/mprw_dp.sv */
module mprw_dp import mprw_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_op,
  input  logic [CH_W-1:0]     in_channel,
  input  logic [PERIOD_W-1:0] period,
  input  logic [ACT_W-1:0]    active,
  input  cmd_t                cmd,
  output sts_t                sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [RATE_W-1:0]   out_rate [CHANNELS],
  output logic                out_window_full
);

  logic [COUNT_WIDTH-1:0] edge_r    [CHANNELS];
  logic [SUM_W-1:0]       sum_r     [CHANNELS];
  logic [RATE_W-1:0]      rate_r    [CHANNELS];
  logic [RATE_W-1:0]      out_rate_r[CHANNELS];
  logic [RING_DEPTH-1:0]  vld_r;
  logic [PERIOD_W-1:0]    elapsed_r;
  logic [PTR_W-1:0]       ptr_r;
  logic                   wrapped_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [PROD_W-1:0]      prod_r;
  logic                   out_valid_r;

  logic [RING_AW-1:0]     ring_addr;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [COUNT_WIDTH-1:0] old_val;
  logic [SUM_W-1:0]       sum_upd;
  logic [PERIOD_W:0]      tick_next;
  logic [ACT_W-1:0]       act_lim;
  logic [CNT_W-1:0]       edge_idx;

  assign ring_addr = RING_AW'(cnt_r) * RING_AW'(WINDOW_SLOTS) + RING_AW'(ptr_r);
  assign old_val   = vld_r[ring_addr] ? rd_data : '0;
  assign sum_upd   = sum_r[cnt_r] + SUM_W'(edge_r[cnt_r]) - SUM_W'(old_val);
  assign tick_next = {1'b0, elapsed_r} + (PERIOD_W+1)'(1);
  assign act_lim   = (active > ACT_W'(CHANNELS)) ? ACT_W'(CHANNELS) : active;
  assign edge_idx  = CNT_W'(in_channel);

  assign sts.tick_sample = (in_op == OP_TICK) && (tick_next > {1'b0, period});
  assign sts.cnt_last    = (cnt_r == CNT_W'(CHANNELS - 1));
  assign sts.wrapped     = wrapped_r;
  assign sts.out_free    = !out_valid_r || out_ready;

  mprw_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (cmd.upd),
    .wr_addr (ring_addr),
    .wr_data (edge_r[cnt_r]),
    .rd_en   (cmd.rd),
    .rd_addr (ring_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        edge_r[c] <= '0;
        sum_r[c]  <= '0;
        rate_r[c] <= '0;
      end
      vld_r       <= '0;
      elapsed_r   <= '0;
      ptr_r       <= '0;
      wrapped_r   <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.take_in) begin
        if (in_op == OP_EDGE) begin
          if (edge_r[edge_idx] != COUNT_MAX) begin
            edge_r[edge_idx] <= edge_r[edge_idx] + COUNT_WIDTH'(1);
          end
        end else if (sts.tick_sample) begin
          elapsed_r <= '0;
        end else begin
          elapsed_r <= tick_next[PERIOD_W-1:0];
        end
      end

      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end

      if (cmd.upd) begin
        sum_r[cnt_r]     <= sum_upd;
        edge_r[cnt_r]    <= '0;
        vld_r[ring_addr] <= 1'b1;
      end

      if (cmd.adv) begin
        if (ptr_r == PTR_W'(WINDOW_SLOTS - 1)) begin
          ptr_r     <= '0;
          wrapped_r <= 1'b1;
        end else begin
          ptr_r <= ptr_r + PTR_W'(1);
        end
      end

      if (cmd.str && (ACT_W'(cnt_r) < act_lim)) begin
        rate_r[cnt_r] <= prod_r[DIV_SHIFT +: RATE_W];
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(sum_r[cnt_r]) * PROD_W'(MULT_W'(DIV_MULT));
    end
    if (cmd.emit) begin
      for (int c = 0; c < CHANNELS; c++) begin
        out_rate_r[c] <= rate_r[c];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rate        = out_rate_r;
  assign out_window_full = 1'b1;

endmodule

/* hdl/multichannel_pulse_rate_window.sv */
// channel   direction  handshake            payload
// in_chan   in         valid/ready          op, channel
// out_chan  out        valid/ready          rate_ch0..rate_ch3, window_full
// apb       in         psel/penable/pready  paddr, pwdata, prdata
//
// an edge or a tick that takes no sample is taken in idle, which it does not leave; a
// sampling tick is taken in idle, reads and updates each channel's ring slot, advances the
// pointer, passes each channel through the shared divide-by-three multiplier, stores its
// rate and posts the word; before the ring has wrapped it goes back to idle after the first
// multiply; the input is taken while a word waits at the output; a sample stalls in emit
// until the output register is free; rst_n is synchronous and clears counts, sums and rates
module multichannel_pulse_rate_window import mprw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  mprw_in_if.sink            in_chan,
  mprw_out_if.source         out_chan,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  logic [PERIOD_W-1:0] period_r;
  logic [ACT_W-1:0]    active_r;
  reg_idx_t            reg_idx;
  cmd_t                cmd;
  sts_t                sts;
  logic [RATE_W-1:0]   rates [CHANNELS];

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      active_r <= ACTIVE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_PERIOD: period_r <= pwdata[PERIOD_W-1:0];
        REG_ACTIVE: active_r <= pwdata[ACT_W-1:0];
        default:    period_r <= period_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PERIOD: prdata = APB_DW'(period_r);
      REG_ACTIVE: prdata = APB_DW'(active_r);
      default:    prdata = '0;
    endcase
  end

  mprw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mprw_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_chan.op),
    .in_channel      (in_chan.channel),
    .period          (period_r),
    .active          (active_r),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_rate        (rates),
    .out_window_full (out_chan.window_full)
  );

  assign out_chan.rate_ch0 = rates[0];
  assign out_chan.rate_ch1 = rates[1];
  assign out_chan.rate_ch2 = rates[2];
  assign out_chan.rate_ch3 = rates[3];

endmodule
